// ----- rtl/assert_macros.svh -----
// Assertion macros used by the result queue of the NMEA sentence receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked at every rising clock edge while reset is released.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- rtl/nsr_pkg.sv -----
// Types, codes and a helper function shared by the NMEA sentence receiver.
`default_nettype none

package nsr_pkg;

  localparam logic [1:0] KIND_CHAR    = 2'd0;
  localparam logic [1:0] KIND_FIELD   = 2'd1;
  localparam logic [1:0] KIND_SENT    = 2'd2;

  localparam logic [1:0] ST_GOOD      = 2'd0;
  localparam logic [1:0] ST_BAD       = 2'd1;
  localparam logic [1:0] ST_NO_CHK    = 2'd2;
  localparam logic [1:0] ST_OVERRUN   = 2'd3;

  localparam logic [6:0] CH_DOLLAR    = 7'h24;
  localparam logic [6:0] CH_CR        = 7'h0d;
  localparam logic [6:0] CH_LF        = 7'h0a;
  localparam logic [6:0] CH_COMMA     = 7'h2c;
  localparam logic [6:0] CH_STAR      = 7'h2a;

  localparam logic [7:0] LIMIT_RESET  = 8'd82;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] ch;
    logic [7:0] idx;
    logic [1:0] status;
    logic       last;
  } nsr_result_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  val;
  } nsr_hex_t;

  function automatic nsr_hex_t hex_decode(input logic [6:0] c);
    nsr_hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 7'h30 && c <= 7'h39) begin
      h.val = 4'(c - 7'h30);
    end else if (c >= 7'h61 && c <= 7'h66) begin
      h.val = 4'(c - 7'h57);
    end else if (c >= 7'h41 && c <= 7'h46) begin
      h.val = 4'(c - 7'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/nsr_res_queue.sv -----
// Result queue: takes up to two results per cycle and hands out one per transfer.
`default_nettype none

module nsr_res_queue
  import nsr_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [1:0]  push_n_i,
  input  nsr_result_t      push0_i,
  input  nsr_result_t      push1_i,
  output logic             room2_o,
  input  wire logic        pop_i,
  output logic             valid_o,
  output nsr_result_t      head_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  nsr_result_t     mem_q [DEPTH];
  logic [PW-1:0]   wr_q, wr_d, wr_p1, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign do_pop  = pop_i && valid_o;
  assign valid_o = (cnt_q != '0);
  assign room2_o = (cnt_q <= CW'(DEPTH - 2));
  assign head_o  = mem_q[rd_q];
  assign wr_p1   = ptr_inc(wr_q);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = do_pop ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q + CW'(push_n_i) - CW'(do_pop);
    if (push_n_i == 2'd1) begin
      wr_d = wr_p1;
    end else if (push_n_i == 2'd2) begin
      wr_d = ptr_inc(wr_p1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_p1] <= push1_i;
    end
  end

`include "assert_macros.svh"

  `ASSERT_RST(a_cnt_bound, clk_i, rst_ni, cnt_q <= CW'(DEPTH))
  `ASSERT_RST(a_push_room, clk_i, rst_ni, (push_n_i != 2'd0) |-> room2_o)
  `ASSERT_RST(a_pop_only, clk_i, rst_ni,
    (do_pop && push_n_i == 2'd0) |=> cnt_q == $past(cnt_q) - CW'(1))
  `ASSERT_RST(a_pair_ends, clk_i, rst_ni,
    (push_n_i == 2'd2) |-> (!push0_i.last && push1_i.last))

endmodule

`default_nettype wire

// ----- rtl/nmea_sentence_receiver.sv -----
// Top level of the NMEA sentence receiver: byte parser state and result output.
//
//  Channel  Direction  Carries
//  s_axis   in         one received byte per transfer (bit 7 ignored)
//  m_axis   out        field characters, field ends, sentence ends with status
//  cfg      in         line_limit register write
//
// Each byte is parsed in the cycle it is accepted; its results are registered in the
// queue, whose head drives m_axis directly. A byte gives at most two results.
// The input takes a byte in every cycle while the queue has two free entries,
// so with one result per byte the rate is one byte per cycle.
// Reset returns the parser to scanning for a dollar sign and empties the queue.
`default_nettype none

module nmea_sentence_receiver
  import nsr_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,   // [6:0] char_out, [14:7] field_index,
                                             // [16:15] status, [23:17] zero
  output logic [1:0]       m_axis_tuser_o,   // [1:0] kind
  output logic             m_axis_tlast_o,   // is_last
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i
);

  logic [7:0]  limit_q;
  logic        in_sent_q, in_sent_d;
  logic [7:0]  cnt_q, cnt_d, cnt_new;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  fc_q, fc_d;
  logic        nonempty_q, nonempty_d;
  logic        star_q, star_d;
  logic [1:0]  ccnt_q, ccnt_d;
  logic [7:0]  cval_q, cval_d;
  logic        hexok_q, hexok_d;

  logic        accept;
  logic [6:0]  c;
  nsr_hex_t    hx;
  logic [7:0]  chk;
  logic [1:0]  push_n;
  nsr_result_t r0, r1, head;
  logic        room2;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = room2;
  assign c               = s_axis_tdata_i[6:0];
  assign hx              = hex_decode(c);
  assign cnt_new         = cnt_q + 8'd1;
  assign chk             = (ccnt_q == 2'd2 && hexok_q) ? cval_q : 8'd0;

  always_comb begin
    in_sent_d  = in_sent_q;
    cnt_d      = cnt_q;
    xor_d      = xor_q;
    fc_d       = fc_q;
    nonempty_d = nonempty_q;
    star_d     = star_q;
    ccnt_d     = ccnt_q;
    cval_d     = cval_q;
    hexok_d    = hexok_q;
    push_n     = 2'd0;
    r0         = '0;
    r1         = '0;
    if (accept) begin
      if (!in_sent_q) begin
        if (c == CH_DOLLAR) begin
          in_sent_d  = 1'b1;
          cnt_d      = '0;
          xor_d      = '0;
          fc_d       = '0;
          nonempty_d = 1'b0;
          star_d     = 1'b0;
          ccnt_d     = '0;
          cval_d     = '0;
          hexok_d    = 1'b1;
        end
      end else if (c == CH_CR) begin
        push_n = 2'd0;
      end else if (c == CH_LF) begin
        in_sent_d = 1'b0;
        r0.kind   = KIND_SENT;
        r0.idx    = fc_q;
        r0.last   = 1'b1;
        push_n    = 2'd1;
        if (!star_q) begin
          r0.status = ST_NO_CHK;
          if (nonempty_q) begin
            r0         = '0;
            r0.kind    = KIND_FIELD;
            r0.idx     = fc_q;
            r1.kind    = KIND_SENT;
            r1.idx     = fc_q + 8'd1;
            r1.status  = ST_NO_CHK;
            r1.last    = 1'b1;
            fc_d       = fc_q + 8'd1;
            nonempty_d = 1'b0;
            push_n     = 2'd2;
          end
        end else begin
          r0.status = (chk == xor_q) ? ST_GOOD : ST_BAD;
        end
      end else begin
        cnt_d = cnt_new;
        if ({1'b0, cnt_new} + 9'd2 > {1'b0, limit_q}) begin
          in_sent_d = 1'b0;
          r0.kind   = KIND_SENT;
          r0.idx    = fc_q;
          r0.status = ST_OVERRUN;
          r0.last   = 1'b1;
          push_n    = 2'd1;
        end else if (star_q) begin
          if (ccnt_q != 2'd3) begin
            ccnt_d = ccnt_q + 2'd1;
          end
          if (hx.ok) begin
            cval_d = {cval_q[3:0], hx.val};
          end else begin
            hexok_d = 1'b0;
          end
        end else if (c == CH_COMMA || c == CH_STAR) begin
          if (c == CH_COMMA) begin
            xor_d = xor_q ^ {1'b0, c};
          end else begin
            star_d = 1'b1;
          end
          r0.kind    = KIND_FIELD;
          r0.idx     = fc_q;
          r0.last    = 1'b1;
          push_n     = 2'd1;
          fc_d       = fc_q + 8'd1;
          nonempty_d = 1'b0;
        end else begin
          xor_d      = xor_q ^ {1'b0, c};
          nonempty_d = 1'b1;
          r0.kind    = KIND_CHAR;
          r0.ch      = c;
          r0.idx     = fc_q;
          r0.last    = 1'b1;
          push_n     = 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q    <= LIMIT_RESET;
      in_sent_q  <= 1'b0;
      cnt_q      <= '0;
      xor_q      <= '0;
      fc_q       <= '0;
      nonempty_q <= 1'b0;
      star_q     <= 1'b0;
      ccnt_q     <= '0;
      cval_q     <= '0;
      hexok_q    <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      in_sent_q  <= in_sent_d;
      cnt_q      <= cnt_d;
      xor_q      <= xor_d;
      fc_q       <= fc_d;
      nonempty_q <= nonempty_d;
      star_q     <= star_d;
      ccnt_q     <= ccnt_d;
      cval_q     <= cval_d;
      hexok_q    <= hexok_d;
    end
  end

  nsr_res_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .push0_i  (r0),
    .push1_i  (r1),
    .room2_o  (room2),
    .pop_i    (m_axis_tready_i),
    .valid_o  (m_axis_tvalid_o),
    .head_o   (head)
  );

  assign m_axis_tdata_o = {7'd0, head.status, head.idx, head.ch};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.last;

endmodule

`default_nettype wire
